@@ rtl/can_text_frame_parser_defines.svh @@
// ----------------------------------------------------------------------------
// can_text_frame_parser_defines.svh
// Assertion macros shared by the text frame parser modules.
// ----------------------------------------------------------------------------
`ifndef CAN_TEXT_FRAME_PARSER_DEFINES_SVH
`define CAN_TEXT_FRAME_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CANTP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cantp assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CANTP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cantp assertion failed");

`endif

@@ rtl/cantp_pkg.sv @@
// ----------------------------------------------------------------------------
// cantp_pkg
// Types, character codes and helpers of the text CAN frame parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cantp_pkg;

    localparam logic [7:0] CHAR_HASH = 8'h23;
    localparam logic [7:0] CHAR_DOT  = 8'h2E;
    localparam logic [7:0] CHAR_R_UP = 8'h52;
    localparam logic [7:0] CHAR_R_LO = 8'h72;

    localparam int unsigned ID_EFF_BIT = 31;
    localparam int unsigned ID_RTR_BIT = 30;
    localparam int unsigned ID_ERR_BIT = 29;

    localparam logic [3:0] SHORT_ID_DIGITS = 4'd3;
    localparam logic [3:0] LONG_ID_DIGITS  = 4'd8;

    localparam logic KIND_DATA_BYTE = 1'b0;
    localparam logic KIND_FRAME_END = 1'b1;

    localparam logic [1:0] STATUS_INVALID = 2'd0;
    localparam logic [1:0] STATUS_CLASSIC = 2'd1;
    localparam logic [1:0] STATUS_FD      = 2'd2;

    typedef enum logic [2:0] {
        PH_ID,
        PH_AFTER_ID,
        PH_RTR_DLC,
        PH_FD_FLAGS,
        PH_DATA,
        PH_DONE
    } cantp_phase_t;

    typedef struct packed {
        logic        result_kind;
        logic [5:0]  byte_index;
        logic [7:0]  byte_value;
        logic [31:0] frame_id;
        logic [6:0]  payload_length;
        logic [3:0]  fd_flags;
        logic [1:0]  parse_status;
        logic        final_result;
    } cantp_result_t;

    // Results caused by one character: zero, one or two of them.
    typedef struct packed {
        logic [1:0]    count;
        cantp_result_t first;
        cantp_result_t second;
    } cantp_step_t;

    // Value of a hex digit, or 16 when the character is not a hex digit.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = 5'd16;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = 5'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = 5'(c - 8'h37);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = 5'(c - 8'h57);
        end
        return v;
    endfunction

endpackage

`default_nettype wire

@@ rtl/cantp_core.sv @@
// ----------------------------------------------------------------------------
// cantp_core
// Parse state registers and the per-character decode of the frame text.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "can_text_frame_parser_defines.svh"

module cantp_core #(
    parameter int CLASSIC_MAX_BYTES = 8,
    parameter int FD_MAX_BYTES      = 64
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  step,
    input  wire logic [7:0]            text_char,
    input  wire logic                  end_of_text,
    output cantp_pkg::cantp_step_t     step_results
);
    import cantp_pkg::*;

    localparam logic [6:0] CLASSIC_LIM = 7'(CLASSIC_MAX_BYTES);
    localparam logic [6:0] FD_LIM      = 7'(FD_MAX_BYTES);

    cantp_phase_t phase_reg, phase_next;
    logic [3:0]   char_pos_reg, char_pos_next;
    logic [31:0]  id_reg, id_next;
    logic [3:0]   held_reg, held_next;
    logic         nib_reg, nib_next;
    logic [6:0]   bytes_reg, bytes_next;
    logic         is_fd_reg, is_fd_next;
    logic         dot_reg, dot_next;
    logic [3:0]   flags_reg, flags_next;
    logic         failed_reg, failed_next;

    logic [4:0]    hv;
    logic          hex_ok;
    logic [6:0]    limit;
    logic          do_data;
    logic          emit;
    logic [7:0]    byte_val;
    logic          frame_ok;
    cantp_result_t byte_res;
    cantp_result_t end_res;

    assign hv     = hex_value(text_char);
    assign hex_ok = ~hv[4];
    assign limit  = is_fd_reg ? FD_LIM : CLASSIC_LIM;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_ID;
            char_pos_reg <= '0;
            id_reg       <= '0;
            held_reg     <= '0;
            nib_reg      <= 1'b0;
            bytes_reg    <= '0;
            is_fd_reg    <= 1'b0;
            dot_reg      <= 1'b1;
            flags_reg    <= '0;
            failed_reg   <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            char_pos_reg <= char_pos_next;
            id_reg       <= id_next;
            held_reg     <= held_next;
            nib_reg      <= nib_next;
            bytes_reg    <= bytes_next;
            is_fd_reg    <= is_fd_next;
            dot_reg      <= dot_next;
            flags_reg    <= flags_next;
            failed_reg   <= failed_next;
        end
    end

    always_comb
    begin
        phase_next    = phase_reg;
        char_pos_next = char_pos_reg;
        id_next       = id_reg;
        held_next     = held_reg;
        nib_next      = nib_reg;
        bytes_next    = bytes_reg;
        is_fd_next    = is_fd_reg;
        dot_next      = dot_reg;
        flags_next    = flags_reg;
        failed_next   = failed_reg;
        do_data       = 1'b0;
        emit          = 1'b0;
        byte_val      = '0;
        frame_ok      = 1'b0;
        byte_res      = '0;
        end_res       = '0;
        step_results  = '0;

        if (step && !failed_reg)
        begin
            case (phase_reg)
                PH_ID:
                begin
                    if (char_pos_reg == SHORT_ID_DIGITS && text_char == CHAR_HASH)
                    begin
                        phase_next = PH_AFTER_ID;
                    end
                    else if (char_pos_reg == LONG_ID_DIGITS)
                    begin
                        if (text_char != CHAR_HASH)
                        begin
                            failed_next = 1'b1;
                        end
                        else
                        begin
                            if (!id_reg[ID_ERR_BIT])
                            begin
                                id_next[ID_EFF_BIT] = 1'b1;
                            end
                            phase_next = PH_AFTER_ID;
                        end
                    end
                    else if (!hex_ok)
                    begin
                        failed_next = 1'b1;
                    end
                    else
                    begin
                        id_next       = {id_reg[27:0], hv[3:0]};
                        char_pos_next = char_pos_reg + 4'd1;
                    end
                end
                PH_AFTER_ID:
                begin
                    if (text_char == CHAR_R_UP || text_char == CHAR_R_LO)
                    begin
                        id_next[ID_RTR_BIT] = 1'b1;
                        phase_next          = PH_RTR_DLC;
                    end
                    else if (text_char == CHAR_HASH)
                    begin
                        is_fd_next = 1'b1;
                        phase_next = PH_FD_FLAGS;
                    end
                    else
                    begin
                        phase_next = PH_DATA;
                        do_data    = 1'b1;
                    end
                end
                PH_RTR_DLC:
                begin
                    if ({2'b00, hv} <= CLASSIC_LIM)
                    begin
                        bytes_next = {2'b00, hv};
                    end
                    phase_next = PH_DONE;
                end
                PH_FD_FLAGS:
                begin
                    if (!hex_ok)
                    begin
                        failed_next = 1'b1;
                    end
                    else
                    begin
                        flags_next = hv[3:0];
                        phase_next = PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    do_data = 1'b1;
                end
                default:
                begin
                end
            endcase

            // Data digits: one optional dot, then two hex digits per byte.
            if (do_data)
            begin
                if (bytes_reg >= limit)
                begin
                    phase_next = PH_DONE;
                end
                else if (!nib_reg)
                begin
                    if (text_char == CHAR_DOT && dot_reg)
                    begin
                        dot_next = 1'b0;
                    end
                    else if (!hex_ok)
                    begin
                        failed_next = 1'b1;
                    end
                    else
                    begin
                        held_next = hv[3:0];
                        nib_next  = 1'b1;
                    end
                end
                else if (!hex_ok)
                begin
                    failed_next = 1'b1;
                end
                else
                begin
                    emit       = 1'b1;
                    byte_val   = {held_reg, hv[3:0]};
                    bytes_next = bytes_reg + 7'd1;
                    nib_next   = 1'b0;
                    dot_next   = 1'b1;
                    if (bytes_reg + 7'd1 >= limit)
                    begin
                        phase_next = PH_DONE;
                    end
                end
            end
        end

        byte_res.result_kind  = KIND_DATA_BYTE;
        byte_res.byte_index   = bytes_reg[5:0];
        byte_res.byte_value   = byte_val;
        byte_res.final_result = !end_of_text;

        frame_ok = !failed_next && phase_next != PH_ID && phase_next != PH_FD_FLAGS
                   && !(phase_next == PH_DATA && nib_next);
        end_res.result_kind  = KIND_FRAME_END;
        end_res.final_result = 1'b1;
        if (frame_ok)
        begin
            end_res.frame_id       = id_next;
            end_res.payload_length = bytes_next;
            end_res.fd_flags       = is_fd_next ? flags_next : 4'd0;
            end_res.parse_status   = is_fd_next ? STATUS_FD : STATUS_CLASSIC;
        end
        else
        begin
            end_res.parse_status = STATUS_INVALID;
        end

        if (step)
        begin
            if (emit)
            begin
                step_results.first = byte_res;
                if (end_of_text)
                begin
                    step_results.second = end_res;
                    step_results.count  = 2'd2;
                end
                else
                begin
                    step_results.count = 2'd1;
                end
            end
            else if (end_of_text)
            begin
                step_results.first = end_res;
                step_results.count = 2'd1;
            end
        end

        // The last character of a frame returns every register to reset.
        if (step && end_of_text)
        begin
            phase_next    = PH_ID;
            char_pos_next = '0;
            id_next       = '0;
            held_next     = '0;
            nib_next      = 1'b0;
            bytes_next    = '0;
            is_fd_next    = 1'b0;
            dot_next      = 1'b1;
            flags_next    = '0;
            failed_next   = 1'b0;
        end
    end

    `CANTP_ASSERT_NEXT(a_end_resets_phase, step && end_of_text, phase_reg == PH_ID)
    `CANTP_ASSERT_NEXT(a_failed_sticks, failed_reg && !(step && end_of_text), failed_reg)
    `CANTP_ASSERT_NOW(a_no_byte_after_fail, failed_reg, !emit)

endmodule

`default_nettype wire

@@ rtl/cantp_out_queue.sv @@
// ----------------------------------------------------------------------------
// cantp_out_queue
// Four-entry result queue taking up to two results a cycle, one out a cycle while head_ready is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "can_text_frame_parser_defines.svh"

module cantp_out_queue (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire cantp_pkg::cantp_step_t push,
    output logic                        room,
    output logic                        head_valid,
    input  wire logic                   head_ready,
    output cantp_pkg::cantp_result_t    head
);
    import cantp_pkg::*;

    localparam int QDEPTH = 4;

    cantp_result_t entry_reg [QDEPTH];
    cantp_result_t entry_next [QDEPTH];
    cantp_result_t shifted [QDEPTH];
    logic [2:0]    count_reg, count_next;
    logic          pop;
    logic [2:0]    base;

    assign head_valid = count_reg != 3'd0;
    assign head       = entry_reg[0];
    assign pop        = head_valid && head_ready;
    assign room       = count_reg <= 3'(QDEPTH - 2);
    assign base       = count_reg - {2'b00, pop};

    for (genvar g = 0; g < QDEPTH; g++)
    begin : g_shift
        if (g < QDEPTH - 1)
        begin : g_mid
            assign shifted[g] = entry_reg[g + 1];
        end
        else
        begin : g_top
            assign shifted[g] = entry_reg[g];
        end
    end

    always_comb
    begin
        for (int i = 0; i < QDEPTH; i++)
        begin
            if (3'(i) < base)
            begin
                entry_next[i] = pop ? shifted[i] : entry_reg[i];
            end
            else if (3'(i) == base && push.count != 2'd0)
            begin
                entry_next[i] = push.first;
            end
            else if (3'(i) == base + 3'd1 && push.count == 2'd2)
            begin
                entry_next[i] = push.second;
            end
            else
            begin
                entry_next[i] = entry_reg[i];
            end
        end
        count_next = base + {1'b0, push.count};
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QDEPTH; i++)
        begin
            entry_reg[i] <= entry_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    `CANTP_ASSERT_NOW(a_count_bounded, 1'b1, count_reg <= 3'(QDEPTH))
    `CANTP_ASSERT_NOW(a_push_needs_room, push.count != 2'd0, room)
    `CANTP_ASSERT_NEXT(a_single_grows, push.count == 2'd1 && !pop && count_reg < 3'(QDEPTH),
                       count_reg == $past(count_reg) + 3'd1)

endmodule

`default_nettype wire

@@ rtl/can_text_frame_parser.sv @@
// ----------------------------------------------------------------------------
// can_text_frame_parser
// Streaming parser for socketcan-style text CAN frames, one character a cycle while in_ready is high.
// ----------------------------------------------------------------------------
// Usage: characters of a frame such as 123#DEADBEEF, 12345678#R4 or 123##1AA.BB
// arrive on the input channel (in_valid/in_ready, text_char, end_of_text), one
// per transaction, end_of_text high on the last character of the string.
// Each decoded data byte leaves on the output channel (out_valid/out_ready) as
// a data-byte result as soon as its second hex digit is taken. The last
// character also yields a frame-end result carrying the identifier with its
// flag bits, the length, the FD flags nibble and the parse status. When that
// status is invalid, the consumer drops the bytes already received for it.
// A result is registered in the queue before it is output. Throughput: one
// character per cycle while in_ready is high; a character that yields both a
// byte and a frame end puts two results into the queue, byte result first.
// Results pass through a four-entry queue; in_ready is high while at least
// two entries are free, so a stalled receiver stops input after the queue
// fills and nothing is lost. Reset (rst_n low) empties the queue and returns
// the parser to the identifier phase; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module can_text_frame_parser #(
    parameter int CLASSIC_MAX_BYTES = 8,
    parameter int FD_MAX_BYTES      = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  text_char,
    input  wire logic        end_of_text,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             result_kind,
    output logic [5:0]       byte_index,
    output logic [7:0]       byte_value,
    output logic [31:0]      frame_id,
    output logic [6:0]       payload_length,
    output logic [3:0]       fd_flags,
    output logic [1:0]       parse_status,
    output logic             final_result
);
    import cantp_pkg::*;

    logic          accept;
    cantp_step_t   step_results;
    cantp_result_t head;

    // A character is decoded in the cycle it is taken; the parse state
    // registers hold everything carried to the next character.
    assign accept = in_valid && in_ready;

    cantp_core #(
        .CLASSIC_MAX_BYTES (CLASSIC_MAX_BYTES),
        .FD_MAX_BYTES      (FD_MAX_BYTES)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (accept),
        .text_char    (text_char),
        .end_of_text  (end_of_text),
        .step_results (step_results)
    );

    // The queue parts the two sides, so input keeps flowing while a result
    // waits for the receiver.
    cantp_out_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (step_results),
        .room       (in_ready),
        .head_valid (out_valid),
        .head_ready (out_ready),
        .head       (head)
    );

    assign result_kind    = head.result_kind;
    assign byte_index     = head.byte_index;
    assign byte_value     = head.byte_value;
    assign frame_id       = head.frame_id;
    assign payload_length = head.payload_length;
    assign fd_flags       = head.fd_flags;
    assign parse_status   = head.parse_status;
    assign final_result   = head.final_result;

endmodule

`default_nettype wire
